// ----- src/fpt_pkg.sv -----
// Shared codes, reset constants and control types for the flow pulse totalizer.
`timescale 1ns / 1ps
`default_nettype none

package fpt_pkg;

    // Item kinds.
    localparam logic [2:0] KIND_PULSE   = 3'd0;
    localparam logic [2:0] KIND_TICK    = 3'd1;
    localparam logic [2:0] KIND_CHECK   = 3'd2;
    localparam logic [2:0] KIND_COMMAND = 3'd3;

    // Bus command codes.
    localparam logic [7:0] CMD_NONE      = 8'h00;
    localparam logic [7:0] CMD_HEARTBEAT = 8'h01;
    localparam logic [7:0] CMD_CLEAR     = 8'h02;
    localparam logic [7:0] CMD_SET       = 8'h03;
    localparam logic [7:0] CMD_ENTER     = 8'h04;
    localparam logic [7:0] CMD_FINISH    = 8'h05;
    localparam logic [7:0] CMD_CANCEL    = 8'h06;

    // Configuration register indexes.
    localparam logic [7:0] CFG_TIMEOUT  = 8'd0;
    localparam logic [7:0] CFG_DISABLED = 8'd1;

    // Reset values and data byte count of a full word.
    localparam logic [15:0] DEFAULT_TIMEOUT_MS       = 16'd7500;
    localparam logic [31:0] DEFAULT_VOLUME_PER_PULSE = 32'd170;
    localparam logic [4:0]  WORD_BYTE_COUNT          = 5'd4;
    localparam logic [4:0]  DIV_LAST_STEP            = 5'd31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic commit;
    } fpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
    } fpt_sts_t;

endpackage

`default_nettype wire

// ----- src/fpt_ctrl.sv -----
// Controller state machine: item sequencing, divide steps and output handshake.
`timescale 1ns / 1ps
`default_nettype none

module fpt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire fpt_pkg::fpt_sts_t sts,
    output fpt_pkg::fpt_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/fpt_dp.sv -----
// Datapath: totalizer state, configuration, iterative ceiling divider and result registers.
`timescale 1ns / 1ps
`default_nettype none

module fpt_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [2:0]        kind,
    input  wire logic [7:0]        command_code,
    input  wire logic [4:0]        data_byte_count,
    input  wire logic [31:0]       data_word,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire fpt_pkg::fpt_cmd_t cmd,
    output fpt_pkg::fpt_sts_t      sts,
    output logic [31:0]            total_volume_out,
    output logic                   calibrating,
    output logic                   error_indicator,
    output logic                   reset_request,
    output logic                   persist_strobe,
    output logic [31:0]            persist_value
);

    // Latched item.
    logic [2:0]  kind_reg;
    logic [7:0]  code_reg;
    logic [4:0]  count_reg;
    logic [31:0] word_reg;

    // Configuration.
    logic [15:0] timeout_reg;
    logic        disabled_reg;

    // Block state.
    logic [31:0] total_reg, total_next;
    logic [31:0] vpp_reg, vpp_next;
    logic [31:0] pulses_reg, pulses_next;
    logic        cal_reg, cal_next;
    logic        err_reg, err_next;
    logic [16:0] age_reg, age_next;
    logic        rreq_next, strobe_next;

    // Divider.
    logic [31:0] rem_reg, quo_reg;
    logic [4:0]  step_reg;
    logic [32:0] partial;
    logic        fits;
    logic [32:0] diff;
    logic [31:0] ceil_quo;

    // Result registers.
    logic [31:0] total_out_reg, persist_out_reg;
    logic        cal_out_reg, err_out_reg, rreq_out_reg, strobe_out_reg;

    assign sts.need_div = (kind_reg == fpt_pkg::KIND_COMMAND)
                          && (code_reg == fpt_pkg::CMD_FINISH)
                          && cal_reg
                          && (count_reg == fpt_pkg::WORD_BYTE_COUNT);
    assign sts.div_last = (step_reg == fpt_pkg::DIV_LAST_STEP);

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign partial = {rem_reg, quo_reg[31]};
    assign diff    = partial - {1'b0, pulses_reg};
    assign fits    = (partial >= {1'b0, pulses_reg});

    // Round up on a remainder; a zero count gives all ones.
    assign ceil_quo = (pulses_reg == 32'd0) ? 32'hFFFF_FFFF
                    : quo_reg + {31'd0, (rem_reg != 32'd0)};

    // Item latch and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg  <= kind;
            code_reg  <= command_code;
            count_reg <= data_byte_count;
            word_reg  <= data_word;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= 32'd0;
            quo_reg  <= word_reg;
            step_reg <= 5'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? diff[31:0] : partial[31:0];
            quo_reg  <= {quo_reg[30:0], fits};
            step_reg <= step_reg + 5'd1;
        end
    end

    // Effect of the latched item on the state.
    always_comb
    begin
        total_next  = total_reg;
        vpp_next    = vpp_reg;
        pulses_next = pulses_reg;
        cal_next    = cal_reg;
        err_next    = err_reg;
        age_next    = age_reg;
        rreq_next   = 1'b0;
        strobe_next = 1'b0;
        unique case (kind_reg)
            fpt_pkg::KIND_PULSE:
            begin
                total_next = total_reg + vpp_reg;
                if (cal_reg)
                begin
                    pulses_next = pulses_reg + 32'd1;
                end
            end
            fpt_pkg::KIND_TICK:
            begin
                if (age_reg != '1)
                begin
                    age_next = age_reg + 17'd1;
                end
            end
            fpt_pkg::KIND_CHECK:
            begin
                if ((age_reg > {1'b0, timeout_reg}) && !disabled_reg)
                begin
                    rreq_next = 1'b1;
                    err_next  = 1'b1;
                end
            end
            fpt_pkg::KIND_COMMAND:
            begin
                unique case (code_reg)
                    fpt_pkg::CMD_NONE:
                    begin
                    end
                    fpt_pkg::CMD_HEARTBEAT:
                    begin
                        age_next = 17'd0;
                    end
                    fpt_pkg::CMD_CLEAR:
                    begin
                        err_next   = 1'b0;
                        total_next = 32'd0;
                    end
                    fpt_pkg::CMD_SET:
                    begin
                        if (count_reg != fpt_pkg::WORD_BYTE_COUNT)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            vpp_next    = word_reg;
                            strobe_next = 1'b1;
                        end
                    end
                    fpt_pkg::CMD_ENTER:
                    begin
                        // Entering always raises the error flag.
                        err_next = 1'b1;
                        if (!cal_reg)
                        begin
                            cal_next    = 1'b1;
                            pulses_next = 32'd0;
                            total_next  = 32'd0;
                        end
                    end
                    fpt_pkg::CMD_FINISH:
                    begin
                        if (cal_reg)
                        begin
                            err_next = 1'b0;
                            if (count_reg == fpt_pkg::WORD_BYTE_COUNT)
                            begin
                                vpp_next    = ceil_quo;
                                strobe_next = 1'b1;
                                cal_next    = 1'b0;
                                pulses_next = 32'd0;
                                total_next  = 32'd0;
                            end
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    fpt_pkg::CMD_CANCEL:
                    begin
                        if (cal_reg)
                        begin
                            err_next    = 1'b0;
                            cal_next    = 1'b0;
                            pulses_next = 32'd0;
                            total_next  = 32'd0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // State and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= fpt_pkg::DEFAULT_TIMEOUT_MS;
            disabled_reg <= 1'b0;
            total_reg    <= 32'd0;
            vpp_reg      <= fpt_pkg::DEFAULT_VOLUME_PER_PULSE;
            pulses_reg   <= 32'd0;
            cal_reg      <= 1'b0;
            err_reg      <= 1'b0;
            age_reg      <= 17'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                    fpt_pkg::CFG_DISABLED: disabled_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                total_reg  <= total_next;
                vpp_reg    <= vpp_next;
                pulses_reg <= pulses_next;
                cal_reg    <= cal_next;
                err_reg    <= err_next;
                age_reg    <= age_next;
            end
        end
    end

    // Result registers, loaded with the state after the item.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            total_out_reg   <= total_next;
            cal_out_reg     <= cal_next;
            err_out_reg     <= err_next;
            rreq_out_reg    <= rreq_next;
            strobe_out_reg  <= strobe_next;
            persist_out_reg <= vpp_next;
        end
    end

    assign total_volume_out = total_out_reg;
    assign calibrating      = cal_out_reg;
    assign error_indicator  = err_out_reg;
    assign reset_request    = rreq_out_reg;
    assign persist_strobe   = strobe_out_reg;
    assign persist_value    = persist_out_reg;

endmodule

`default_nettype wire

// ----- src/flow_pulse_totalizer_core.sv -----
// Top level of the flow pulse totalizer: controller, datapath and checks.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    kind, command_code, data_byte_count, data_word
// result   out        out_valid / out_ready  total_volume_out, calibrating, error_indicator,
//                                            reset_request, persist_strobe, persist_value
// config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes through accept, decode and commit; a calibration finish that divides
// also runs one restoring step a cycle of the quotient unit between decode and commit.
// One item is in work at a time; the next is accepted while a result waits in the
// output register, and its commit waits until that result is taken.
// Reset is asynchronous and active low; configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module flow_pulse_totalizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  command_code,
    input  wire logic [4:0]  data_byte_count,
    input  wire logic [31:0] data_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      total_volume_out,
    output logic             calibrating,
    output logic             error_indicator,
    output logic             reset_request,
    output logic             persist_strobe,
    output logic [31:0]      persist_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    fpt_pkg::fpt_cmd_t cmd;
    fpt_pkg::fpt_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    fpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // State, divider and result registers.
    fpt_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .kind             (kind),
        .command_code     (command_code),
        .data_byte_count  (data_byte_count),
        .data_word        (data_word),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .total_volume_out (total_volume_out),
        .calibrating      (calibrating),
        .error_indicator  (error_indicator),
        .reset_request    (reset_request),
        .persist_strobe   (persist_strobe),
        .persist_value    (persist_value)
    );

    // An accepted item blocks the input until its work is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after an item");

    // A reset request always comes with the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reset_request) |-> error_indicator)
    else $error("reset request without error flag");

    // A watchdog check never stores a volume per pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reset_request && persist_strobe))
    else $error("reset request and persist strobe on one result");

    // A new result only appears while the input side is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
    else $error("result shown while an item is still in work");

endmodule

`default_nettype wire
